FILE: sv/pts_pkg.sv
// Shared types, sizes and codes for the priority task scheduler.
package pts_pkg;

    localparam int MAX_SLOTS   = 16;
    localparam int PRIO_LEVELS = 8;
    localparam int IDX_W       = $clog2(MAX_SLOTS);

    localparam int FUNC_W   = 3;
    localparam int PRIO_W   = 3;
    localparam int ID_W     = 16;
    localparam int TIME_W   = 32;
    localparam int DUR_W    = 16;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [DUR_W-1:0] SLICE_RESET = DUR_W'(10);

    typedef enum logic [FUNC_W-1:0] {
        FN_CREATE   = 3'd0,
        FN_DELETE   = 3'd1,
        FN_DISPATCH = 3'd2,
        FN_FINISH   = 3'd3,
        FN_YIELD    = 3'd4,
        FN_DELAY    = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 3'd0,
        STS_BAD_PRIO = 3'd1,
        STS_NO_SLOT  = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_NO_TASK  = 3'd4,
        STS_NO_READY = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        MODE_FREE  = 2'd0,
        MODE_READY = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_BLOCK = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREEMPT = 1'd0,
        CFG_SLICE   = 1'd1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_WAKE,
        ST_PICK,
        ST_DSEL,
        ST_DPUSH,
        ST_ACT,
        ST_RESP
    } t_state;

    // Commands from controller to slot table; all act at one slot index.
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              load_clock;
        logic [TIME_W-1:0] now;
        logic              push;
        logic              unlink;
        logic              mode_wr;
        t_mode             mode;
        logic              ident_wr;
        logic [ID_W-1:0]   ident;
        logic              prio_wr;
        logic [PRIO_W-1:0] prio;
        logic              wake_clr;
        logic              wake_set;
        logic [DUR_W-1:0]  delay;
        logic              best_clr;
        logic              best_upd;
    } t_dp_cmd;

    typedef struct packed {
        t_mode            mode;
        logic [ID_W-1:0]  ident;
        logic             wake_hit;
        logic             best_valid;
        logic [IDX_W-1:0] best_idx;
    } t_dp_stat;

endpackage

FILE: sv/priority_task_scheduler.sv
// Top level of the fixed-priority task scheduler.
//  channel  dir  handshake             payload
//  in       in   i_in_valid/o_in_stall  func prio target_id now_ms delay_ms ran_ms
//  out      out  o_out_valid/i_out_stall status task_id slot switched
//  cfg      in   i_cfg_we              i_cfg_idx i_cfg_data
// One item at a time; the slot scan walks one slot per cycle.
// create/delete: slot scan then apply; dispatch: wake scan, pick scan, select, and a push
// of a preempted task; finish/yield/delay: one action; all end in the result register.
// Reset frees all slots, clears running task and time, sets next id to one.
// A held result stalls only the final step; the next item is taken once it is loaded.
module priority_task_scheduler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [pts_pkg::FUNC_W-1:0]     i_func,
    input  logic [pts_pkg::PRIO_W-1:0]     i_prio,
    input  logic [pts_pkg::ID_W-1:0]       i_target_id,
    input  logic [pts_pkg::TIME_W-1:0]     i_now_ms,
    input  logic [pts_pkg::DUR_W-1:0]      i_delay_ms,
    input  logic [pts_pkg::DUR_W-1:0]      i_ran_ms,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [pts_pkg::STATUS_W-1:0]   o_status,
    output logic [pts_pkg::ID_W-1:0]       o_task_id,
    output logic [pts_pkg::SLOT_W-1:0]     o_slot,
    output logic                           o_switched,
    input  logic                           i_cfg_we,
    input  logic [pts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pts_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pts_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_prio      (i_prio),
        .i_target_id (i_target_id),
        .i_now_ms    (i_now_ms),
        .i_delay_ms  (i_delay_ms),
        .i_ran_ms    (i_ran_ms),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_task_id   (o_task_id),
        .o_slot      (o_slot),
        .o_switched  (o_switched),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    pts_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule

FILE: sv/pts_datapath.sv
// Slot table, ready ordering ranks, time base and best-candidate tracking.
module pts_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pts_pkg::t_dp_cmd  i_cmd,
    output pts_pkg::t_dp_stat o_stat
);
    import pts_pkg::*;

    // Rank 0 is the head of the ready order; ranks are dense among ready slots.
    t_mode             r_mode  [MAX_SLOTS];
    t_mode             n_mode  [MAX_SLOTS];
    logic [ID_W-1:0]   r_ident [MAX_SLOTS];
    logic [ID_W-1:0]   n_ident [MAX_SLOTS];
    logic [PRIO_W-1:0] r_prio  [MAX_SLOTS];
    logic [PRIO_W-1:0] n_prio  [MAX_SLOTS];
    logic [IDX_W-1:0]  r_rank  [MAX_SLOTS];
    logic [IDX_W-1:0]  n_rank  [MAX_SLOTS];
    logic [TIME_W-1:0] r_wake  [MAX_SLOTS];
    logic [TIME_W-1:0] n_wake  [MAX_SLOTS];
    logic [TIME_W-1:0] r_clock, n_clock;
    logic              r_best_valid, n_best_valid;
    logic [IDX_W-1:0]  r_best_idx, n_best_idx;
    logic [PRIO_W-1:0] r_best_prio, n_best_prio;
    logic [IDX_W-1:0]  r_best_rank, n_best_rank;

    t_mode             cur_mode;
    logic [PRIO_W-1:0] cur_prio;
    logic [IDX_W-1:0]  cur_rank;
    logic [TIME_W-1:0] cur_wake;

    always_comb begin
        cur_mode = r_mode[i_cmd.idx];
        cur_prio = r_prio[i_cmd.idx];
        cur_rank = r_rank[i_cmd.idx];
        cur_wake = r_wake[i_cmd.idx];

        n_mode  = r_mode;
        n_ident = r_ident;
        n_prio  = r_prio;
        n_rank  = r_rank;
        n_wake  = r_wake;
        n_clock = r_clock;
        n_best_valid = r_best_valid;
        n_best_idx   = r_best_idx;
        n_best_prio  = r_best_prio;
        n_best_rank  = r_best_rank;

        if (i_cmd.load_clock) begin
            n_clock = i_cmd.now;
        end
        if (i_cmd.push) begin
            for (int j = 0; j < MAX_SLOTS; j++) begin
                if (r_mode[j] == MODE_READY && IDX_W'(j) != i_cmd.idx) begin
                    n_rank[j] = r_rank[j] + 1'b1;
                end
            end
            n_rank[i_cmd.idx] = '0;
            n_mode[i_cmd.idx] = MODE_READY;
        end
        if (i_cmd.unlink) begin
            for (int j = 0; j < MAX_SLOTS; j++) begin
                if (r_mode[j] == MODE_READY && r_rank[j] > cur_rank) begin
                    n_rank[j] = r_rank[j] - 1'b1;
                end
            end
        end
        if (i_cmd.mode_wr) begin
            n_mode[i_cmd.idx] = i_cmd.mode;
        end
        if (i_cmd.ident_wr) begin
            n_ident[i_cmd.idx] = i_cmd.ident;
        end
        if (i_cmd.prio_wr) begin
            n_prio[i_cmd.idx] = i_cmd.prio;
        end
        if (i_cmd.wake_clr) begin
            n_wake[i_cmd.idx] = '0;
        end
        if (i_cmd.wake_set) begin
            n_wake[i_cmd.idx] = r_clock + TIME_W'(i_cmd.delay);
        end
        if (i_cmd.best_clr) begin
            n_best_valid = 1'b0;
        end
        if (i_cmd.best_upd && cur_mode == MODE_READY &&
            (!r_best_valid || cur_prio > r_best_prio ||
             (cur_prio == r_best_prio && cur_rank < r_best_rank))) begin
            n_best_valid = 1'b1;
            n_best_idx   = i_cmd.idx;
            n_best_prio  = cur_prio;
            n_best_rank  = cur_rank;
        end

        o_stat.mode       = cur_mode;
        o_stat.ident      = r_ident[i_cmd.idx];
        o_stat.wake_hit   = cur_mode == MODE_BLOCK && cur_wake != '0 && r_clock >= cur_wake;
        o_stat.best_valid = r_best_valid;
        o_stat.best_idx   = r_best_idx;
    end

    always_ff @(posedge i_clk) begin
        r_ident     <= n_ident;
        r_prio      <= n_prio;
        r_rank      <= n_rank;
        r_wake      <= n_wake;
        r_best_idx  <= n_best_idx;
        r_best_prio <= n_best_prio;
        r_best_rank <= n_best_rank;
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_SLOTS; j++) begin
                r_mode[j] <= MODE_FREE;
            end
            r_clock      <= '0;
            r_best_valid <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_clock      <= n_clock;
            r_best_valid <= n_best_valid;
        end
    end

endmodule

FILE: sv/pts_ctrl.sv
// Operation sequencer: slot scans, list updates, running task and result register.
module pts_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [pts_pkg::FUNC_W-1:0]     i_func,
    input  logic [pts_pkg::PRIO_W-1:0]     i_prio,
    input  logic [pts_pkg::ID_W-1:0]       i_target_id,
    input  logic [pts_pkg::TIME_W-1:0]     i_now_ms,
    input  logic [pts_pkg::DUR_W-1:0]      i_delay_ms,
    input  logic [pts_pkg::DUR_W-1:0]      i_ran_ms,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [pts_pkg::STATUS_W-1:0]   o_status,
    output logic [pts_pkg::ID_W-1:0]       o_task_id,
    output logic [pts_pkg::SLOT_W-1:0]     o_slot,
    output logic                           o_switched,
    input  logic                           i_cfg_we,
    input  logic [pts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pts_pkg::t_dp_cmd               o_cmd,
    input  pts_pkg::t_dp_stat              i_stat
);
    import pts_pkg::*;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    t_func             r_func, n_func;
    logic [PRIO_W-1:0] r_prio, n_prio;
    logic [ID_W-1:0]   r_target, n_target;
    logic [DUR_W-1:0]  r_delay, n_delay;
    logic [DUR_W-1:0]  r_ran, n_ran;
    logic [IDX_W-1:0]  r_slot, n_slot;
    logic              r_has_slot, n_has_slot;
    logic              r_use_ident, n_use_ident;
    logic [ID_W-1:0]   r_tid, n_tid;
    t_status           r_status, n_status;
    logic              r_sw, n_sw;
    logic [IDX_W-1:0]  r_run, n_run;
    logic              r_run_valid, n_run_valid;
    logic [IDX_W-1:0]  r_old, n_old;
    logic [ID_W-1:0]   r_id_ctr, n_id_ctr;
    logic              r_preempt;
    logic [DUR_W-1:0]  r_slice;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [ID_W-1:0]   r_out_tid, n_out_tid;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic              r_out_sw, n_out_sw;

    logic             last;
    logic             hit;
    logic [ID_W-1:0]  id_inc;

    always_comb begin
        n_state = r_state;   n_cnt = r_cnt;       n_func = r_func;
        n_prio = r_prio;     n_target = r_target; n_delay = r_delay;
        n_ran = r_ran;       n_slot = r_slot;     n_has_slot = r_has_slot;
        n_use_ident = r_use_ident; n_tid = r_tid; n_status = r_status;
        n_sw = r_sw;         n_run = r_run;       n_run_valid = r_run_valid;
        n_old = r_old;       n_id_ctr = r_id_ctr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_status = r_out_status; n_out_tid = r_out_tid;
        n_out_slot = r_out_slot;     n_out_sw = r_out_sw;

        o_cmd     = '0;
        o_cmd.idx = r_cnt;
        o_cmd.now = i_now_ms;
        o_cmd.ident = r_id_ctr;
        o_cmd.prio  = r_prio;
        o_cmd.delay = r_delay;
        o_cmd.mode  = MODE_FREE;
        o_in_stall  = r_state != ST_IDLE;

        last   = r_cnt == IDX_W'(MAX_SLOTS - 1);
        hit    = 1'b0;
        id_inc = r_id_ctr + 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_func = t_func'(i_func);
                    n_prio = i_prio;
                    n_target = i_target_id;
                    n_delay = i_delay_ms;
                    n_ran = i_ran_ms;
                    n_cnt = '0;
                    n_has_slot = 1'b0;
                    n_use_ident = 1'b0;
                    n_tid = '0;
                    n_sw = 1'b0;
                    n_status = STS_OK;
                    n_state = ST_RESP;
                    case (t_func'(i_func))
                        FN_CREATE: begin
                            if (int'(i_prio) >= PRIO_LEVELS) begin
                                n_status = STS_BAD_PRIO;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        FN_DELETE: begin
                            if (i_target_id == '0) begin
                                n_status = STS_NOT_FOUND;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        FN_DISPATCH: begin
                            o_cmd.load_clock = 1'b1;
                            n_state = ST_WAKE;
                        end
                        FN_FINISH, FN_YIELD, FN_DELAY: begin
                            if (!r_run_valid) begin
                                n_status = STS_NO_TASK;
                            end else begin
                                n_state = ST_ACT;
                            end
                        end
                        default: begin
                            n_status = STS_OK;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_func == FN_CREATE) begin
                    hit = i_stat.mode == MODE_FREE;
                end else begin
                    hit = i_stat.mode != MODE_FREE && i_stat.ident == r_target;
                end
                if (hit) begin
                    n_slot = r_cnt;
                    n_state = ST_APPLY;
                end else if (last) begin
                    n_status = (r_func == FN_CREATE) ? STS_NO_SLOT : STS_NOT_FOUND;
                    n_state = ST_RESP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_APPLY: begin
                o_cmd.idx = r_slot;
                n_has_slot = 1'b1;
                if (r_func == FN_CREATE) begin
                    o_cmd.ident_wr = 1'b1;
                    o_cmd.prio_wr = 1'b1;
                    o_cmd.wake_clr = 1'b1;
                    o_cmd.push = 1'b1;
                    n_tid = r_id_ctr;
                    // id zero is reserved for free slots
                    n_id_ctr = (id_inc == '0) ? ID_W'(1) : id_inc;
                end else begin
                    o_cmd.unlink = i_stat.mode == MODE_READY;
                    o_cmd.mode_wr = 1'b1;
                    o_cmd.mode = MODE_FREE;
                    o_cmd.ident_wr = 1'b1;
                    o_cmd.ident = '0;
                    n_tid = r_target;
                    if (r_run_valid && r_run == r_slot) begin
                        n_run_valid = 1'b0;
                    end
                end
                n_state = ST_RESP;
            end
            ST_WAKE: begin
                o_cmd.push = i_stat.wake_hit;
                if (last) begin
                    n_cnt = '0;
                    o_cmd.best_clr = 1'b1;
                    n_state = ST_PICK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_PICK: begin
                o_cmd.best_upd = 1'b1;
                if (last) begin
                    n_state = ST_DSEL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DSEL: begin
                n_state = ST_RESP;
                if (!i_stat.best_valid) begin
                    n_status = STS_NO_READY;
                end else begin
                    o_cmd.idx = i_stat.best_idx;
                    o_cmd.unlink = 1'b1;
                    o_cmd.mode_wr = 1'b1;
                    o_cmd.mode = MODE_RUN;
                    n_slot = i_stat.best_idx;
                    n_has_slot = 1'b1;
                    n_use_ident = 1'b1;
                    n_sw = !r_run_valid || r_run != i_stat.best_idx;
                    n_run = i_stat.best_idx;
                    n_run_valid = 1'b1;
                    n_old = r_run;
                    if (r_run_valid && r_run != i_stat.best_idx) begin
                        n_state = ST_DPUSH;
                    end
                end
            end
            ST_DPUSH: begin
                // preempted task goes back to the head of its list
                o_cmd.idx = r_old;
                o_cmd.push = 1'b1;
                n_state = ST_RESP;
            end
            ST_ACT: begin
                o_cmd.idx = r_run;
                n_slot = r_run;
                n_has_slot = 1'b1;
                n_use_ident = 1'b1;
                case (r_func)
                    FN_FINISH: begin
                        if (r_preempt && r_ran >= r_slice) begin
                            o_cmd.push = 1'b1;
                            n_run_valid = 1'b0;
                        end
                    end
                    FN_YIELD: begin
                        o_cmd.push = 1'b1;
                        n_run_valid = 1'b0;
                    end
                    default: begin
                        o_cmd.wake_set = 1'b1;
                        o_cmd.mode_wr = 1'b1;
                        o_cmd.mode = MODE_BLOCK;
                        n_run_valid = 1'b0;
                    end
                endcase
                n_state = ST_RESP;
            end
            ST_RESP: begin
                o_cmd.idx = r_slot;
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_status = r_status;
                    n_out_tid = r_use_ident ? i_stat.ident : r_tid;
                    n_out_slot = r_has_slot ? SLOT_W'(r_slot) : '0;
                    n_out_sw = r_sw;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;       r_func <= n_func;     r_prio <= n_prio;
        r_target <= n_target; r_delay <= n_delay;   r_ran <= n_ran;
        r_slot <= n_slot;     r_has_slot <= n_has_slot;
        r_use_ident <= n_use_ident; r_tid <= n_tid; r_status <= n_status;
        r_sw <= n_sw;         r_run <= n_run;       r_old <= n_old;
        r_out_status <= n_out_status; r_out_tid <= n_out_tid;
        r_out_slot <= n_out_slot;     r_out_sw <= n_out_sw;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_run_valid <= 1'b0;
            r_id_ctr <= ID_W'(1);
            r_out_valid <= 1'b0;
            r_preempt <= 1'b0;
            r_slice <= SLICE_RESET;
        end else begin
            r_state <= n_state;
            r_run_valid <= n_run_valid;
            r_id_ctr <= n_id_ctr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    CFG_PREEMPT: r_preempt <= i_cfg_data[0];
                    CFG_SLICE:   r_slice <= i_cfg_data[DUR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_task_id   = r_out_tid;
    assign o_slot      = r_out_slot;
    assign o_switched  = r_out_sw;

endmodule

FILE: tb/sv/pts_checker.sv
// Checker for the priority task scheduler: mirrors the scheduler state and compares results.
module pts_checker
    import pts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [PRIO_W-1:0]     i_prio,
    input  logic [ID_W-1:0]       i_target_id,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic [DUR_W-1:0]      i_delay_ms,
    input  logic [DUR_W-1:0]      i_ran_ms,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [STATUS_W-1:0]   i_status,
    input  logic [ID_W-1:0]       i_task_id,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic                  i_switched,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results,
    output int                    o_dispatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NONE = MAX_SLOTS;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     task_id;
        logic [SLOT_W-1:0]   slot;
        logic                switched;
    } t_sched_res;

    logic [ID_W-1:0]   ident [MAX_SLOTS];
    t_mode             mode  [MAX_SLOTS];
    logic [PRIO_W-1:0] tprio [MAX_SLOTS];
    int                nxt   [MAX_SLOTS];
    int                prv   [MAX_SLOTS];
    logic [TIME_W-1:0] wake  [MAX_SLOTS];
    int                head  [PRIO_LEVELS];
    int                running;
    logic [TIME_W-1:0] clock_ms;
    logic [ID_W-1:0]   next_id;
    logic              preempt;
    logic [DUR_W-1:0]  slice;

    t_sched_res expected_results[$];

    function automatic void push_ready(int s);
        int p;
        p = tprio[s];
        nxt[s] = head[p];
        prv[s] = NONE;
        if (head[p] < NONE) prv[head[p]] = s;
        head[p] = s;
        mode[s] = MODE_READY;
    endfunction

    function automatic void unlink(int s);
        if (prv[s] < NONE) nxt[prv[s]] = nxt[s];
        else head[tprio[s]] = nxt[s];
        if (nxt[s] < NONE) prv[nxt[s]] = prv[s];
        nxt[s] = NONE;
        prv[s] = NONE;
    endfunction

    function automatic t_sched_res schedule(logic [FUNC_W-1:0] fn, logic [PRIO_W-1:0] pr,
            logic [ID_W-1:0] tgt, logic [TIME_W-1:0] now, logic [DUR_W-1:0] dly,
            logic [DUR_W-1:0] ran);
        t_sched_res r;
        int s;
        int old;
        r = '0;
        s = NONE;
        case (fn)
            FN_CREATE: begin
                for (int i = MAX_SLOTS - 1; i >= 0; i--)
                    if (mode[i] == MODE_FREE) s = i;
                if (s == NONE) begin
                    r.status = STS_NO_SLOT;
                end else begin
                    r.task_id = next_id;
                    next_id++;
                    if (next_id == 0) next_id = 1;
                    ident[s] = r.task_id;
                    tprio[s] = pr;
                    wake[s] = '0;
                    push_ready(s);
                end
            end
            FN_DELETE: begin
                if (tgt != 0)
                    for (int i = MAX_SLOTS - 1; i >= 0; i--)
                        if (mode[i] != MODE_FREE && ident[i] == tgt) s = i;
                if (s == NONE) begin
                    r.status = STS_NOT_FOUND;
                end else begin
                    if (mode[s] == MODE_READY) unlink(s);
                    if (running == s) running = NONE;
                    mode[s] = MODE_FREE;
                    ident[s] = '0;
                    r.task_id = tgt;
                end
            end
            FN_DISPATCH: begin
                old = running;
                clock_ms = now;
                for (int i = 0; i < MAX_SLOTS; i++)
                    if (mode[i] == MODE_BLOCK && wake[i] != 0 && clock_ms >= wake[i])
                        push_ready(i);
                for (int p = PRIO_LEVELS - 1; p >= 0 && s == NONE; p--)
                    if (head[p] < NONE) begin
                        s = head[p];
                        unlink(s);
                    end
                if (s == NONE) begin
                    r.status = STS_NO_READY;
                end else begin
                    if (old < NONE && old != s) push_ready(old);
                    r.switched = (old != s);
                    running = s;
                    mode[s] = MODE_RUN;
                    r.task_id = ident[s];
                end
            end
            FN_FINISH, FN_YIELD, FN_DELAY: begin
                s = running;
                if (s == NONE) begin
                    r.status = STS_NO_TASK;
                end else begin
                    r.task_id = ident[s];
                    if (fn == FN_DELAY) begin
                        mode[s] = MODE_BLOCK;
                        wake[s] = clock_ms + dly;
                        running = NONE;
                    end else if (fn == FN_YIELD || (preempt && ran >= slice)) begin
                        push_ready(s);
                        running = NONE;
                    end
                end
            end
            default: ;
        endcase
        r.slot = (s < NONE) ? SLOT_W'(s) : '0;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0d, expected %0d (result %0d)",
            what, got, want, o_results);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_sched_res want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                ident[i] = '0;
                mode[i] = MODE_FREE;
                tprio[i] = '0;
                nxt[i] = NONE;
                prv[i] = NONE;
                wake[i] = '0;
            end
            for (int p = 0; p < PRIO_LEVELS; p++) head[p] = NONE;
            running = NONE;
            clock_ms = '0;
            next_id = 1;
            preempt = 1'b0;
            slice = SLICE_RESET;
            expected_results.delete();
            o_pending = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PREEMPT) preempt = i_cfg_data[0];
                else slice = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_func == FN_DISPATCH) o_dispatches++;
                expected_results.push_back(schedule(i_func, i_prio, i_target_id, i_now_ms,
                    i_delay_ms, i_ran_ms));
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (expected_results.size() == 0) begin
                    report("unexpected result", 32'd1, 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_status != want.status)
                        report("status", 32'(i_status), 32'(want.status));
                    if (i_task_id != want.task_id)
                        report("task_id", 32'(i_task_id), 32'(want.task_id));
                    if (i_slot != want.slot)
                        report("slot", 32'(i_slot), 32'(want.slot));
                    if (i_switched != want.switched)
                        report("switched", 32'(i_switched), 32'(want.switched));
                end
            end
            o_pending = expected_results.size();
        end
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_results = 0;
        o_dispatches = 0;
    end
endmodule

FILE: tb/sv/testbench.sv
// Testbench top for the priority task scheduler: stimulus, configuration and verdict.
module testbench;
    import pts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 2 * MAX_SLOTS + 8;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [FUNC_W-1:0]     func = '0;
    logic [PRIO_W-1:0]     prio = '0;
    logic [ID_W-1:0]       target_id = '0;
    logic [TIME_W-1:0]     now_ms = '0;
    logic [DUR_W-1:0]      delay_ms = '0;
    logic [DUR_W-1:0]      ran_ms = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [ID_W-1:0]       task_id;
    logic [SLOT_W-1:0]     slot;
    logic                  switched;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    errors, pending, results, dispatches;
    int                    idle_cycles = 0;
    int                    stall_mode = 0;
    logic [ID_W-1:0]       id_seen = '0;
    logic [TIME_W-1:0]     sim_ms = '0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    priority_task_scheduler dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_func(func), .i_prio(prio), .i_target_id(target_id), .i_now_ms(now_ms),
        .i_delay_ms(delay_ms), .i_ran_ms(ran_ms),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_task_id(task_id), .o_slot(slot), .o_switched(switched),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    pts_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_func(func), .i_prio(prio), .i_target_id(target_id), .i_now_ms(now_ms),
        .i_delay_ms(delay_ms), .i_ran_ms(ran_ms),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_status(status), .i_task_id(task_id), .i_slot(slot), .i_switched(switched),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_dispatches(dispatches)
    );

    // Receiver stalls in moods: none, light, heavy.
    always @(posedge clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        if (out_valid && !out_stall) id_seen <= task_id;
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send(logic [FUNC_W-1:0] f, logic [PRIO_W-1:0] p, logic [ID_W-1:0] t,
            logic [TIME_W-1:0] n, logic [DUR_W-1:0] d, logic [DUR_W-1:0] r);
        func <= f;
        prio <= p;
        target_id <= t;
        now_ms <= n;
        delay_ms <= d;
        ran_ms <= r;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic gap();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed traffic: creates, deletes, dispatches, and actions on the runner.
    task automatic random_item();
        int k;
        logic [FUNC_W-1:0] f;
        logic [ID_W-1:0] t;
        logic [PRIO_W-1:0] p;
        logic [DUR_W-1:0] d;
        logic [DUR_W-1:0] r;
        k = $urandom_range(0, 99);
        if (k < 18) f = FN_CREATE;
        else if (k < 28) f = FN_DELETE;
        else if (k < 55) f = FN_DISPATCH;
        else if (k < 70) f = FN_FINISH;
        else if (k < 82) f = FN_YIELD;
        else if (k < 96) f = FN_DELAY;
        else f = FUNC_W'($urandom_range(6, 7));
        t = ($urandom_range(0, 2) != 0) ? ID_W'(id_seen - ID_W'($urandom_range(0, 3)))
                                        : ID_W'($urandom());
        if ($urandom_range(0, 9) == 0) sim_ms = $urandom();
        else sim_ms = sim_ms + $urandom_range(0, 40);
        p = PRIO_W'($urandom());
        d = DUR_W'(($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 60));
        r = DUR_W'(($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 30));
        send(f, p, t, sim_ms, d, r);
        if ($urandom_range(0, 15) == 0) gap();
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty cases, fill table, priorities, delay/wake, deletes.
        send(FN_DISPATCH, 0, 0, 0, 0, 0);
        send(FN_FINISH, 0, 0, 0, 0, 0);
        send(FN_YIELD, 0, 0, 0, 0, 0);
        send(FN_DELAY, 0, 0, 0, 0, 0);
        send(FN_DELETE, 0, 16'd0, 0, 0, 0);
        send(3'd6, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send(3'd7, 0, 0, 0, 0, 0);
        for (int i = 0; i < MAX_SLOTS + 1; i++) send(FN_CREATE, PRIO_W'(i), 0, 0, 0, 0);
        send(FN_DISPATCH, 0, 0, 32'd100, 0, 0);
        send(FN_DELAY, 0, 0, 0, 16'hFFFF, 0);
        send(FN_DISPATCH, 0, 0, 32'hFFFF_FFFF, 0, 0);
        send(FN_DELETE, 0, 16'd16, 0, 0, 0);
        send(FN_FINISH, 0, 0, 0, 0, 16'hFFFF);
        quiesce();

        write_reg(CFG_PREEMPT, 1);
        write_reg(CFG_SLICE, 0);
        repeat (500) random_item();
        quiesce();
        write_reg(CFG_SLICE, 16'hFFFF);
        repeat (400) random_item();
        quiesce();
        write_reg(CFG_PREEMPT, 0);
        write_reg(CFG_SLICE, 16'd10);
        repeat (400) random_item();
        quiesce();
        write_reg(CFG_PREEMPT, 1);
        write_reg(CFG_SLICE, 16'd15);
        // Preemption back on with a mid-range slice.
        repeat (400) random_item();
        quiesce();

        $display("covered %0d results, %0d dispatches, several preemption settings",
            results, dispatches);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAILURE");
        end
        $finish;
    end
endmodule
